>>> hdl/d4r_pkg.sv
// Shared types, constants and tables for the 4-bit indexed row decoder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package d4r_pkg;

  localparam int unsigned MaxDimDefault = 2048;
  localparam int unsigned NumEntries    = 16;
  localparam int unsigned EntryW        = 4;
  localparam int unsigned ChanW         = 8;
  localparam int unsigned CfgDataW      = 12;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned AddrW         = 22;
  localparam int unsigned DistW         = 18;
  localparam int unsigned SquareW       = 16;
  localparam int unsigned NumLevels     = 4;
  localparam int unsigned LevelW        = 2;

  typedef enum logic {
    KindPalette = 1'b0,
    KindData    = 1'b1
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 2'd0,
    CfgImageHeight = 2'd1,
    CfgRowsBottomUp = 2'd2
  } cfg_idx_e;

  // Component intensities used by the fixed color set.
  localparam logic [ChanW-1:0] LevelValue [NumLevels] = '{8'h00, 8'h55, 8'hAA, 8'hFF};

  // Level codes of each fixed color, ordered red, green, blue.
  localparam logic [LevelW-1:0] CgaLevel [NumEntries][3] = '{
    '{2'd0, 2'd0, 2'd0}, '{2'd0, 2'd0, 2'd2}, '{2'd0, 2'd2, 2'd0}, '{2'd0, 2'd2, 2'd2},
    '{2'd2, 2'd0, 2'd0}, '{2'd2, 2'd0, 2'd2}, '{2'd2, 2'd1, 2'd0}, '{2'd2, 2'd2, 2'd2},
    '{2'd1, 2'd1, 2'd1}, '{2'd1, 2'd1, 2'd3}, '{2'd1, 2'd3, 2'd1}, '{2'd1, 2'd3, 2'd3},
    '{2'd3, 2'd1, 2'd1}, '{2'd3, 2'd1, 2'd3}, '{2'd3, 2'd3, 2'd1}, '{2'd3, 2'd3, 2'd3}
  };

  typedef struct packed {
    logic [AddrW-1:0]  addr;
    logic [EntryW-1:0] color;
    logic              last_item;
    logic              last_image;
  } pixel_t;

endpackage

>>> hdl/d4r_intf.sv
// Handshake channel interfaces of the row decoder: input beats, pixel results
// and register writes. Depends on d4r_pkg for field widths and codes.
`timescale 1ns / 1ps

interface d4r_in_if;
  import d4r_pkg::*;
  logic              valid;
  logic              ready;
  kind_e             kind;
  logic [EntryW-1:0] entry_index;
  logic [ChanW-1:0]  blue;
  logic [ChanW-1:0]  green;
  logic [ChanW-1:0]  red;
  logic [ChanW-1:0]  data_byte;
  modport source (output valid, kind, entry_index, blue, green, red, data_byte,
                  input ready);
  modport sink (input valid, kind, entry_index, blue, green, red, data_byte,
                output ready);
endinterface

interface d4r_out_if;
  import d4r_pkg::*;
  logic              valid;
  logic              ready;
  logic [AddrW-1:0]  pixel_address;
  logic [EntryW-1:0] pixel_color;
  logic              last_of_item;
  logic              last_of_image;
  modport source (output valid, pixel_address, pixel_color, last_of_item, last_of_image,
                  input ready);
  modport sink (input valid, pixel_address, pixel_color, last_of_item, last_of_image,
                output ready);
endinterface

interface d4r_cfg_if;
  import d4r_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/decode_4bpp_rows_with_palette_remap_core.sv
// Top level of the 4-bit indexed row decoder with palette remap to the fixed colors.
// Depends on d4r_pkg and the channel interfaces in d4r_intf.sv.
// A result passes the input register, the work register and the result buffer before it is presented.
// Throughput: one input beat per cycle while the result port is not stalled; a data byte's
// pixel results (one or two) leave one at a time through the single result port, and the input waits for them.
// Reset: the color map reads as zero, position restarts, registers go to width 1,
// height 1, bottom-up rows. There is no clearing pass.
`timescale 1ns / 1ps

module decode_4bpp_rows_with_palette_remap_core #(
  parameter int unsigned MaxDimension = d4r_pkg::MaxDimDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  d4r_in_if.sink          in_i,
  d4r_out_if.source       out_o,
  d4r_cfg_if.sink         cfg_i
);
  import d4r_pkg::*;

  localparam int unsigned DimW      = $clog2(MaxDimension + 1);
  localparam int unsigned StrideMax = ((MaxDimension + 1) / 2 + 3) / 4 * 4;
  localparam int unsigned ByteW     = $clog2(StrideMax + 1);
  localparam int unsigned ProdW     = 2 * DimW;
  localparam int unsigned SumW      = (ProdW + 1 > AddrW) ? ProdW + 1 : AddrW;
  localparam logic [CfgDataW:0] MaxDimExt = (CfgDataW + 1)'(MaxDimension);

  // Configuration registers and clamped dimensions.
  logic [CfgDataW-1:0] width_q, height_q;
  logic                bottom_up_q;
  logic [DimW-1:0]     dim_w, dim_h;

  always_comb begin
    logic [CfgDataW:0] wx, hx;
    wx = {1'b0, width_q};
    hx = {1'b0, height_q};
    if (wx == '0) begin
      dim_w = DimW'(1);
    end else if (wx > MaxDimExt) begin
      dim_w = MaxDimExt[DimW-1:0];
    end else begin
      dim_w = wx[DimW-1:0];
    end
    if (hx == '0) begin
      dim_h = DimW'(1);
    end else if (hx > MaxDimExt) begin
      dim_h = MaxDimExt[DimW-1:0];
    end else begin
      dim_h = hx[DimW-1:0];
    end
  end

  // Input register.
  logic              a_valid_q;
  kind_e             a_kind_q;
  logic [EntryW-1:0] a_entry_q;
  logic [ChanW-1:0]  a_blue_q, a_green_q, a_red_q, a_byte_q;
  logic              a_ready, a_adv;

  // Work register.
  logic              b_valid_q;
  kind_e             b_kind_q;
  logic [EntryW-1:0] b_entry_q;
  logic [DistW-1:0]  b_dist_q [NumEntries];
  logic [ProdW-1:0]  b_prod_q;
  logic [DimW-1:0]   b_x0_q;
  logic [ChanW-1:0]  b_byte_q;
  logic [1:0]        b_n_q;
  logic [1:0]        b_li_q;
  logic              b_ready, b_adv, b_load_c;

  // Result buffer, head entry first.
  logic [1:0]        c_cnt_q;
  pixel_t            c_e0_q, c_e1_q;
  logic              c_free, c_pop;

  // Pixel position state.
  logic [ByteW-1:0]  byte_in_row_q;
  logic [DimW-1:0]   row_count_q;
  logic              image_done_q;

  // Color map storage.
  logic [EntryW-1:0] cmap_mem [NumEntries];
  logic [NumEntries-1:0] cmap_vld_q;

  assign c_pop    = (c_cnt_q != 2'd0) && out_o.ready;
  assign c_free   = (c_cnt_q == 2'd0) || ((c_cnt_q == 2'd1) && out_o.ready);
  assign b_adv    = b_valid_q && ((b_kind_q == KindPalette) || (b_n_q == 2'd0) || c_free);
  assign b_load_c = b_adv && (b_kind_q == KindData) && (b_n_q != 2'd0);
  assign b_ready  = !b_valid_q || b_adv;
  assign a_adv    = a_valid_q && b_ready;
  assign a_ready  = !a_valid_q || a_adv;

  assign in_i.ready  = a_ready;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid         = c_cnt_q != 2'd0;
  assign out_o.pixel_address = c_e0_q.addr;
  assign out_o.pixel_color   = c_e0_q.color;
  assign out_o.last_of_item  = c_e0_q.last_item;
  assign out_o.last_of_image = c_e0_q.last_image;

  // Palette distances from the input register.
  logic [DistW-1:0] sq_dist [NumEntries];

  always_comb begin
    logic [SquareW-1:0] sq_r [NumLevels];
    logic [SquareW-1:0] sq_g [NumLevels];
    logic [SquareW-1:0] sq_b [NumLevels];
    logic [ChanW-1:0]   mr, mg, mb;
    for (int l = 0; l < NumLevels; l++) begin
      mr = (a_red_q >= LevelValue[l]) ? a_red_q - LevelValue[l] : LevelValue[l] - a_red_q;
      mg = (a_green_q >= LevelValue[l]) ? a_green_q - LevelValue[l]
                                        : LevelValue[l] - a_green_q;
      mb = (a_blue_q >= LevelValue[l]) ? a_blue_q - LevelValue[l]
                                       : LevelValue[l] - a_blue_q;
      sq_r[l] = SquareW'(mr) * SquareW'(mr);
      sq_g[l] = SquareW'(mg) * SquareW'(mg);
      sq_b[l] = SquareW'(mb) * SquareW'(mb);
    end
    for (int i = 0; i < NumEntries; i++) begin
      sq_dist[i] = DistW'(sq_r[CgaLevel[i][0]]) + DistW'(sq_g[CgaLevel[i][1]])
                 + DistW'(sq_b[CgaLevel[i][2]]);
    end
  end

  // Pixel placement for a data byte in the input register.
  logic [ByteW-1:0] pix_bytes, stride, bir_next;
  logic [DimW-1:0]  y_pos, x0, x1, w_m1, row_next;
  logic             active, last_row, wrap;
  logic [1:0]       n_res;
  logic [1:0]       li;

  always_comb begin
    logic [DimW:0]  w_p1;
    logic [ByteW:0] rb_p3;
    w_p1      = {1'b0, dim_w} + 1'b1;
    pix_bytes = ByteW'(w_p1 >> 1);
    rb_p3     = {1'b0, pix_bytes} + (ByteW + 1)'(3);
    stride    = ByteW'({rb_p3[ByteW:2], 2'b00});
    w_m1      = dim_w - 1'b1;
    active    = !image_done_q && (byte_in_row_q < pix_bytes);
    y_pos     = bottom_up_q ? (dim_h - 1'b1 - row_count_q) : row_count_q;
    x0        = DimW'({byte_in_row_q, 1'b0});
    x1        = x0 + 1'b1;
    last_row  = row_count_q == (dim_h - 1'b1);
    li[0]     = last_row && (x0 == w_m1);
    li[1]     = last_row && (x1 == w_m1);
    if (!active) begin
      n_res = 2'd0;
    end else if (x1 != dim_w) begin
      n_res = 2'd2;
    end else begin
      n_res = 2'd1;
    end
    bir_next = byte_in_row_q + 1'b1;
    wrap     = bir_next >= stride;
    row_next = row_count_q + 1'b1;
  end

  // Nearest color over the registered distances, lowest index on ties.
  logic [EntryW-1:0] best_idx;

  always_comb begin
    logic [DistW-1:0]  md [NumEntries];
    logic [EntryW-1:0] mi [NumEntries];
    for (int i = 0; i < NumEntries; i++) begin
      md[i] = b_dist_q[i];
      mi[i] = EntryW'(i);
    end
    for (int s = 1; s < NumEntries; s = s * 2) begin
      for (int j = 0; j < NumEntries; j = j + 2 * s) begin
        if (md[j + s] < md[j]) begin
          md[j] = md[j + s];
          mi[j] = mi[j + s];
        end
      end
    end
    best_idx = mi[0];
  end

  // Pixel addresses for the data byte in the work register.
  logic [SumW-1:0] addr0, addr1;
  assign addr0 = SumW'(b_prod_q) + SumW'(b_x0_q);
  assign addr1 = addr0 + 1'b1;

  logic [EntryW-1:0] nib_hi, nib_lo;
  assign nib_hi = b_byte_q[7:4];
  assign nib_lo = b_byte_q[3:0];

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q       <= CfgDataW'(1);
      height_q      <= CfgDataW'(1);
      bottom_up_q   <= 1'b1;
      a_valid_q     <= 1'b0;
      b_valid_q     <= 1'b0;
      c_cnt_q       <= 2'd0;
      byte_in_row_q <= '0;
      row_count_q   <= '0;
      image_done_q  <= 1'b0;
      cmap_vld_q    <= '0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_i.valid;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
      if (b_load_c) begin
        c_cnt_q <= b_n_q;
      end else if (c_pop) begin
        c_cnt_q <= c_cnt_q - 1'b1;
      end
      if (b_adv && (b_kind_q == KindPalette)) begin
        cmap_vld_q[b_entry_q] <= 1'b1;
      end
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CfgImageWidth: begin
            width_q       <= cfg_i.data;
            byte_in_row_q <= '0;
            row_count_q   <= '0;
            image_done_q  <= 1'b0;
          end
          CfgImageHeight: begin
            height_q      <= cfg_i.data;
            byte_in_row_q <= '0;
            row_count_q   <= '0;
            image_done_q  <= 1'b0;
          end
          CfgRowsBottomUp: begin
            bottom_up_q   <= cfg_i.data[0];
            byte_in_row_q <= '0;
            row_count_q   <= '0;
            image_done_q  <= 1'b0;
          end
          default: begin
          end
        endcase
      end else if (a_adv && (a_kind_q == KindData) && !image_done_q) begin
        if (wrap) begin
          byte_in_row_q <= '0;
          row_count_q   <= row_next;
          image_done_q  <= row_next >= dim_h;
        end else begin
          byte_in_row_q <= bir_next;
        end
      end
    end
  end

  // Payload registers and color map storage.
  always_ff @(posedge clk_i) begin
    if (a_ready && in_i.valid) begin
      a_kind_q  <= in_i.kind;
      a_entry_q <= in_i.entry_index;
      a_blue_q  <= in_i.blue;
      a_green_q <= in_i.green;
      a_red_q   <= in_i.red;
      a_byte_q  <= in_i.data_byte;
    end
    if (a_adv) begin
      b_kind_q  <= a_kind_q;
      b_entry_q <= a_entry_q;
      b_dist_q  <= sq_dist;
      b_prod_q  <= ProdW'(y_pos) * ProdW'(dim_w);
      b_x0_q    <= x0;
      b_byte_q  <= a_byte_q;
      b_n_q     <= (a_kind_q == KindData) ? n_res : 2'd0;
      b_li_q    <= li;
    end
    if (b_adv && (b_kind_q == KindPalette)) begin
      cmap_mem[b_entry_q] <= best_idx;
    end
    if (b_load_c) begin
      c_e0_q.addr       <= addr0[AddrW-1:0];
      c_e0_q.color      <= cmap_vld_q[nib_hi] ? cmap_mem[nib_hi] : '0;
      c_e0_q.last_item  <= b_n_q == 2'd1;
      c_e0_q.last_image <= b_li_q[0];
      c_e1_q.addr       <= addr1[AddrW-1:0];
      c_e1_q.color      <= cmap_vld_q[nib_lo] ? cmap_mem[nib_lo] : '0;
      c_e1_q.last_item  <= 1'b1;
      c_e1_q.last_image <= b_li_q[1];
    end else if (c_pop) begin
      c_e0_q <= c_e1_q;
    end
  end

endmodule
